@@ hdl/tsrf_pkg.sv @@
// ----------------------------------------------------------------------------
// Timed-text style run filter package
// Request and result types, register codes and result formatting helpers
// shared by the front, queue, back and top level.
// ----------------------------------------------------------------------------
package tsrf_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FONT_ID   = 3'd0,
    REG_FACE      = 3'd1,
    REG_FONT_SIZE = 3'd2,
    REG_COLOR     = 3'd3,
    REG_ALPHA     = 3'd4
  } reg_idx_e;

  // result kinds
  localparam logic [1:0] KIND_KEPT   = 2'd0;
  localparam logic [1:0] KIND_EMPTY  = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;

  // face bit positions
  localparam int unsigned FACE_BOLD_BIT      = 0;
  localparam int unsigned FACE_ITALIC_BIT    = 1;
  localparam int unsigned FACE_UNDERLINE_BIT = 2;

  localparam logic [23:0] DFLT_COLOR_RST = 24'hFF_FFFF;
  localparam logic [7:0]  DFLT_ALPHA_RST = 8'hFF;

  typedef struct packed {
    logic        first_record;
    logic        last_record;
    logic [15:0] span_start;
    logic [15:0] span_end;
    logic [15:0] font_id;
    logic [7:0]  face_flags;
    logic [7:0]  font_size;
    logic [23:0] color_rgb;
    logic [7:0]  alpha;
  } tsrf_in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] out_start;
    logic [15:0] out_end;
    logic [15:0] out_font_id;
    logic        out_bold;
    logic        out_italic;
    logic        out_underline;
    logic [7:0]  out_font_size;
    logic [23:0] out_color_bgr;
    logic [7:0]  out_alpha;
    logic        list_end;
  } tsrf_out_t;

  typedef struct packed {
    logic [15:0] font_id;
    logic [2:0]  face;
    logic [7:0]  font_size;
    logic [23:0] color;
    logic [7:0]  alpha;
  } tsrf_style_t;

  typedef struct packed {
    logic [15:0] start_pos;
    logic [15:0] end_pos;
    tsrf_style_t style;
  } tsrf_rec_t;

  // one queue entry: one or two results caused by a single request
  typedef struct packed {
    logic      two;
    tsrf_out_t res0;
    tsrf_out_t res1;
  } tsrf_entry_t;

  function automatic logic [23:0] swap_rb(logic [23:0] c);
    return {c[7:0], c[15:8], c[23:16]};
  endfunction

  function automatic tsrf_out_t rec_result(tsrf_rec_t r, logic last);
    tsrf_out_t o;
    o.kind          = KIND_KEPT;
    o.out_start     = r.start_pos;
    o.out_end       = r.end_pos;
    o.out_font_id   = r.style.font_id;
    o.out_bold      = r.style.face[FACE_BOLD_BIT];
    o.out_italic    = r.style.face[FACE_ITALIC_BIT];
    o.out_underline = r.style.face[FACE_UNDERLINE_BIT];
    o.out_font_size = r.style.font_size;
    o.out_color_bgr = swap_rb(r.style.color);
    o.out_alpha     = r.style.alpha;
    o.list_end      = last;
    return o;
  endfunction

  function automatic tsrf_out_t marker_result(logic [1:0] kind);
    tsrf_out_t o;
    o          = '0;
    o.kind     = kind;
    o.list_end = 1'b1;
    return o;
  endfunction

endpackage

@@ hdl/tsrf_front.sv @@
// ----------------------------------------------------------------------------
// Timed-text style run filter front end
// Holds the default style and the held record, classifies each request and
// pushes the results it causes into the queue as one entry.
// ----------------------------------------------------------------------------
module tsrf_front import tsrf_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  tsrf_in_t              in_req_i,
  input  logic                  q_ready_i,
  output logic                  push_o,
  output tsrf_entry_t           push_entry_o
);

  tsrf_style_t dflt_q;
  tsrf_rec_t   pend_q, pend_d;
  logic        pend_valid_q, pend_valid_d;
  logic        failed_q, failed_d;

  logic        acc;
  tsrf_style_t in_style;
  logic        pv_eff, failed_eff, reject, keep, merge, newrec, emit_old, pv_mid;
  tsrf_rec_t   pend_mid;
  tsrf_out_t   final_res;

  assign in_ready_o = q_ready_i;
  assign acc        = in_valid_i & q_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dflt_q <= '{font_id: 16'd0, face: 3'd0, font_size: 8'd0,
                  color: DFLT_COLOR_RST, alpha: DFLT_ALPHA_RST};
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_FONT_ID:   dflt_q.font_id   <= cfg_data_i[15:0];
        REG_FACE:      dflt_q.face      <= cfg_data_i[2:0];
        REG_FONT_SIZE: dflt_q.font_size <= cfg_data_i[7:0];
        REG_COLOR:     dflt_q.color     <= cfg_data_i[23:0];
        REG_ALPHA:     dflt_q.alpha     <= cfg_data_i[7:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    in_style = '{font_id:   in_req_i.font_id,
                 face:      in_req_i.face_flags[2:0],
                 font_size: in_req_i.font_size,
                 color:     in_req_i.color_rgb,
                 alpha:     in_req_i.alpha};

    // a first record opens a fresh list
    pv_eff     = pend_valid_q & ~in_req_i.first_record;
    failed_eff = failed_q & ~in_req_i.first_record;

    reject = (in_req_i.span_end < in_req_i.span_start) |
             (pv_eff & (in_req_i.span_start < pend_q.end_pos));
    keep   = (in_req_i.span_start != in_req_i.span_end) & (in_style != dflt_q);
    merge  = keep & pv_eff & (in_style == pend_q.style) &
             (in_req_i.span_start == pend_q.end_pos);
    newrec   = keep & ~merge;
    emit_old = newrec & pv_eff;

    pend_mid = pend_q;
    if (merge) begin
      pend_mid.end_pos = in_req_i.span_end;
    end
    if (newrec) begin
      pend_mid = '{start_pos: in_req_i.span_start, end_pos: in_req_i.span_end,
                   style: in_style};
    end
    pv_mid    = pv_eff | newrec;
    final_res = pv_mid ? rec_result(pend_mid, 1'b1) : marker_result(KIND_EMPTY);

    push_o            = 1'b0;
    push_entry_o.two  = 1'b0;
    push_entry_o.res0 = final_res;
    push_entry_o.res1 = final_res;
    pend_d            = pend_q;
    pend_valid_d      = pend_valid_q;
    failed_d          = failed_q;

    if (acc) begin
      if (failed_eff) begin
        // drop everything until the next list
        pend_valid_d = pv_eff;
      end else if (reject) begin
        push_o            = 1'b1;
        push_entry_o.res0 = marker_result(KIND_REJECT);
        pend_valid_d      = 1'b0;
        failed_d          = 1'b1;
      end else begin
        failed_d     = 1'b0;
        pend_d       = pend_mid;
        pend_valid_d = pv_mid & ~in_req_i.last_record;
        if (emit_old) begin
          push_o            = 1'b1;
          push_entry_o.res0 = rec_result(pend_q, 1'b0);
          push_entry_o.two  = in_req_i.last_record;
        end else if (in_req_i.last_record) begin
          push_o = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      failed_q     <= 1'b0;
    end else begin
      pend_valid_q <= pend_valid_d;
      failed_q     <= failed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
  end

endmodule

@@ hdl/tsrf_queue.sv @@
// ----------------------------------------------------------------------------
// Timed-text style run filter queue
// Small FIFO of result entries between the front end and the back end.
// ----------------------------------------------------------------------------
module tsrf_queue import tsrf_pkg::*; #(
  parameter int unsigned DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  tsrf_entry_t entry_i,
  output logic        ready_o,
  input  logic        pop_i,
  output logic        valid_o,
  output tsrf_entry_t entry_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  tsrf_entry_t      mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign ready_o = (cnt_q != CNT_W'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign entry_o = mem_q[rd_ptr_q];
  assign do_push = push_i & ready_o;
  assign do_pop  = pop_i & valid_o;

  function automatic logic [PTR_W-1:0] next_ptr(logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!do_push && do_pop) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

@@ hdl/tsrf_back.sv @@
// ----------------------------------------------------------------------------
// Timed-text style run filter back end
// Pops queue entries and presents their one or two results on the output
// register, one result per handshake.
// ----------------------------------------------------------------------------
module tsrf_back import tsrf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_valid_i,
  input  tsrf_entry_t q_entry_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output tsrf_out_t   out_req_o
);

  logic      out_valid_q, slot1_valid_q;
  tsrf_out_t out_q, slot1_q;
  logic      out_free;

  assign out_free    = ~out_valid_q | out_ready_i;
  // finish the second result of an entry before taking the next one
  assign pop_o       = out_free & ~slot1_valid_q & q_valid_i;
  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q   <= 1'b0;
      slot1_valid_q <= 1'b0;
    end else if (out_free) begin
      if (slot1_valid_q) begin
        out_valid_q   <= 1'b1;
        slot1_valid_q <= 1'b0;
      end else if (q_valid_i) begin
        out_valid_q   <= 1'b1;
        slot1_valid_q <= q_entry_i.two;
      end else begin
        out_valid_q   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (slot1_valid_q) begin
        out_q <= slot1_q;
      end else if (q_valid_i) begin
        out_q   <= q_entry_i.res0;
        slot1_q <= q_entry_i.res1;
      end
    end
  end

endmodule

@@ hdl/timed_text_style_run_filter.sv @@
// ----------------------------------------------------------------------------
// Timed-text style run filter
// Takes one style record per cycle while in_ready_o is high and returns the
// cleaned style list of a subtitle sample: reversed or overlapping records
// reject the list, empty and default-style records are dropped, adjacent
// equal records merge, and colors leave in BGR order. A record is accepted in
// any cycle in which the result queue (QUEUE_DEPTH entries) has room; its
// results pass through a queue entry and then the output register. The output
// port moves one result per cycle while out_ready_i is high, so a record that
// both pushes out the held record and ends the list occupies the output for
// two results, and the sustained rate is one record per cycle while each
// record gives at most one result and the output is not stalled.
// Default-style registers are written through the plain write port.
// ----------------------------------------------------------------------------
module timed_text_style_run_filter import tsrf_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  tsrf_in_t              in_req_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output tsrf_out_t             out_req_o
);

  logic        q_ready, q_valid, push, pop;
  tsrf_entry_t push_entry, head_entry;

  tsrf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_req_i     (in_req_i),
    .q_ready_i    (q_ready),
    .push_o       (push),
    .push_entry_o (push_entry)
  );

  tsrf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .ready_o (q_ready),
    .pop_i   (pop),
    .valid_o (q_valid),
    .entry_o (head_entry)
  );

  tsrf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_entry_i   (head_entry),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_req_o   (out_req_o)
  );

endmodule

@@ hdl/tsrf_checker.sv @@
// ----------------------------------------------------------------------------
// Timed-text style run filter checker
// Port-level properties of the filter, attached to the top level by bind.
// ----------------------------------------------------------------------------
module tsrf_checker import tsrf_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input tsrf_out_t out_req_o
);

  // a waiting result holds until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_req_o))
    else $error("result dropped or changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_req_o.kind == KIND_KEPT) || (out_req_o.kind == KIND_EMPTY) ||
                    (out_req_o.kind == KIND_REJECT))
    else $error("undefined result kind");

  // markers close the list and carry no record
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_req_o.kind != KIND_KEPT) |->
      out_req_o.list_end && (out_req_o.out_start == '0) && (out_req_o.out_end == '0) &&
      (out_req_o.out_font_id == '0) && (out_req_o.out_color_bgr == '0) &&
      (out_req_o.out_alpha == '0) && (out_req_o.out_font_size == '0))
    else $error("marker result carries record data");

  // kept records are never empty or reversed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_req_o.kind == KIND_KEPT) |->
      out_req_o.out_start < out_req_o.out_end)
    else $error("kept record with empty or reversed span");

endmodule

bind timed_text_style_run_filter tsrf_checker u_tsrf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_req_o   (out_req_o)
);
